// ===== hw/rtl/gcp_pkg.sv =====
// ----------------------------------------------------------------------------
// gcp_pkg
// Shared widths, register indexes, sequencer states and status types of the
// grid cell placer.
// ----------------------------------------------------------------------------
package gcp_pkg;

    localparam int AREA_W     = 13;   // area width and height, cell sizes
    localparam int WGT_W      = 8;    // one packed weight
    localparam int NUM_WGT    = 8;    // weights packed in one register
    localparam int CNT_W      = 4;    // column and row count registers
    localparam int COORD_W    = 16;   // area origin
    localparam int EDGE_W     = 8;    // padding, border, margin
    localparam int PREF_W     = 14;   // preferred size
    localparam int POS_W      = 17;   // result position
    localparam int SIZE_W     = 14;   // result size
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam int DEF_MAX_COLS  = 8;
    localparam int DEF_MAX_ROWS  = 8;
    localparam int DEF_SIZE_BITS = 13;

    localparam logic [CFG_DATA_W-1:0] WEIGHT_RESET = 64'h0101_0101_0101_0101;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COL_COUNT   = 2'd0,
        CFG_ROW_COUNT   = 2'd1,
        CFG_COL_WEIGHTS = 2'd2,
        CFG_ROW_WEIGHTS = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_X,
        ST_DIV_X,
        ST_MUL_Y,
        ST_DIV_Y,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic first;
        logic last;
    } t_edge;

endpackage

// ===== hw/rtl/gcp_if.sv =====
// ----------------------------------------------------------------------------
// gcp_if
// Request, result and register write channels of the grid cell placer.
// ----------------------------------------------------------------------------
interface gcp_req_if import gcp_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic signed [COORD_W-1:0] area_x;
    logic signed [COORD_W-1:0] area_y;
    logic [AREA_W-1:0]         area_w;
    logic [AREA_W-1:0]         area_h;
    logic [EDGE_W-1:0]         pad;
    logic [EDGE_W-1:0]         item_border;
    logic [EDGE_W-1:0]         item_margin;
    logic signed [PREF_W-1:0]  pref_w;
    logic signed [PREF_W-1:0]  pref_h;

    modport source (
        output valid, req_type, area_x, area_y, area_w, area_h, pad,
               item_border, item_margin, pref_w, pref_h,
        input  ready
    );
    modport sink (
        input  valid, req_type, area_x, area_y, area_w, area_h, pad,
               item_border, item_margin, pref_w, pref_h,
        output ready
    );
endinterface

interface gcp_res_if import gcp_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [SIZE_W-1:0] size_w;
    logic signed [SIZE_W-1:0] size_h;

    modport source (output valid, pos_x, pos_y, size_w, size_h, input ready);
    modport sink (input valid, pos_x, pos_y, size_w, size_h, output ready);
endinterface

interface gcp_cfg_if import gcp_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/gcp_divider.sv =====
// ----------------------------------------------------------------------------
// gcp_divider
// Restoring divider, one quotient bit per cycle. The dividend is an area size
// times one weight and the divisor the weight sum, so the quotient never
// exceeds the area size and only the low AREA_W bits need iterations.
// ----------------------------------------------------------------------------
module gcp_divider import gcp_pkg::*; #(
    parameter int DIVR_W = WGT_W + 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [AREA_W+WGT_W-1:0]   i_dividend,
    input  logic [DIVR_W-1:0]         i_divisor,
    output t_div_stat                 o_stat,
    output logic [AREA_W-1:0]         o_quot
);

    localparam int STEP_W = $clog2(AREA_W + 1);

    logic [DIVR_W-1:0] r_rem;
    logic [AREA_W-1:0] r_sh;
    logic [DIVR_W-1:0] r_dvs;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIVR_W:0]   w_trial;
    logic [DIVR_W:0]   w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_sh[AREA_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= STEP_W'(AREA_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // the top bits of the dividend are already below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DIVR_W'(i_dividend[AREA_W+WGT_W-1:AREA_W]);
            r_sh  <= i_dividend[AREA_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIVR_W-1:0] : w_trial[DIVR_W-1:0];
            r_sh  <= {r_sh[AREA_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_sh;

endmodule

// ===== hw/rtl/gcp_axis.sv =====
// ----------------------------------------------------------------------------
// gcp_axis
// One axis of a placement: takes the padding off an edge cell, clips to the
// preferred size, centers the item and adds origin, cursor, border, margin.
// ----------------------------------------------------------------------------
module gcp_axis import gcp_pkg::*; #(
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  logic signed [COORD_W-1:0] i_org,
    input  logic [SIZE_BITS-1:0]      i_cursor,
    input  logic [AREA_W-1:0]         i_cell,
    input  logic [EDGE_W-1:0]         i_pad,
    input  logic [EDGE_W:0]           i_bm,
    input  logic signed [PREF_W-1:0]  i_pref,
    input  t_edge                     i_edge,
    output logic signed [POS_W-1:0]   o_pos,
    output logic signed [SIZE_W-1:0]  o_size
);

    localparam int PC_W  = AREA_W + 2;
    localparam int SUM_W = ((SIZE_BITS > COORD_W - 1) ? SIZE_BITS : COORD_W - 1) + 3;

    logic signed [PC_W-1:0]  w_cell;
    logic signed [PC_W-1:0]  w_pad;
    logic signed [PC_W-1:0]  w_pcell;
    logic signed [PC_W-1:0]  w_pref;
    logic signed [PC_W-1:0]  w_size;
    logic signed [PC_W-1:0]  w_diff;
    logic signed [PC_W-1:0]  w_off;
    logic signed [SUM_W-1:0] w_pos;

    assign w_cell  = $signed({2'b00, i_cell});
    assign w_pad   = $signed(PC_W'(i_pad));
    assign w_pcell = (i_edge.first || i_edge.last) ? (w_cell - w_pad) : w_cell;
    assign w_pref  = PC_W'(i_pref);
    assign w_size  = (i_pref < 0 || w_pref > w_pcell) ? w_pcell : w_pref;
    // difference is never negative, so the shift is the halving
    assign w_diff  = w_pcell - w_size;
    assign w_off   = (w_diff >>> 1) + (i_edge.first ? w_pad : '0)
                   + $signed(PC_W'(i_bm));
    assign w_pos   = SUM_W'(i_org) + $signed(SUM_W'(i_cursor)) + SUM_W'(w_off);

    assign o_pos  = w_pos[POS_W-1:0];
    assign o_size = w_size[SIZE_W-1:0];

endmodule

// ===== hw/rtl/grid_cell_placer.sv =====
// ----------------------------------------------------------------------------
// grid_cell_placer
// Places items cell by cell into a weighted grid, keeping a running cursor.
//
//   channel  dir   handshake       payload
//   i_req    in    valid / ready   req_type, area, pad, border, margin, pref
//   o_res    out   valid / ready   pos_x, pos_y, size_w, size_h
//   i_cfg    in    valid / ready   index, data (always ready)
//
// A placement runs the steps PREP (the weight sums), then for each axis a
// multiply step and the shared serial divider (13 quotient bits, then its
// done flag), then FIN to finish. The next request is taken the cycle after
// the finish. A restart gives no result. Synchronous reset clears cursor
// and registers to their defaults. A result not yet taken holds the finish
// step back; a new request is taken while the result waits.
// ----------------------------------------------------------------------------
module grid_cell_placer import gcp_pkg::*; #(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gcp_req_if.sink      i_req,
    gcp_res_if.source    o_res,
    gcp_cfg_if.sink      i_cfg
);

    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MAX_N   = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int DIVR_W  = WGT_W + $clog2(MAX_N);
    localparam int CUR_W   = ((SIZE_BITS > AREA_W) ? SIZE_BITS : AREA_W) + 1;
    localparam int PROD_W  = AREA_W + WGT_W;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
                                                     input logic [CNT_W-1:0] maxc);
        logic [CNT_W-1:0] res;
        if (c == '0) begin
            res = CNT_W'(1);
        end else if (c > maxc) begin
            res = maxc;
        end else begin
            res = c;
        end
        return res;
    endfunction

    function automatic logic [DIVR_W-1:0] weight_sum(input logic [CFG_DATA_W-1:0] w,
                                                     input logic [CNT_W-1:0] n);
        logic [DIVR_W-1:0] s;
        s = '0;
        for (int i = 0; i < NUM_WGT; i++) begin
            if (CNT_W'(i) < n) begin
                s = s + DIVR_W'(w[WGT_W*i +: WGT_W]);
            end
        end
        return s;
    endfunction

    // registers and sequencer
    logic [CNT_W-1:0]      r_cfg_ncol;
    logic [CNT_W-1:0]      r_cfg_nrow;
    logic [CFG_DATA_W-1:0] r_cfg_wcol;
    logic [CFG_DATA_W-1:0] r_cfg_wrow;
    t_state                r_state;
    t_state                n_state;

    // request fields
    logic signed [COORD_W-1:0] r_ax;
    logic signed [COORD_W-1:0] r_ay;
    logic [AREA_W-1:0]         r_aw;
    logic [AREA_W-1:0]         r_ah;
    logic [EDGE_W-1:0]         r_pad;
    logic [EDGE_W:0]           r_bm;
    logic signed [PREF_W-1:0]  r_pw;
    logic signed [PREF_W-1:0]  r_ph;

    // per-placement working values
    logic [CNT_W-1:0]  r_cols;
    logic [CNT_W-1:0]  r_rows;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [WGT_W-1:0]  r_wc;
    logic [WGT_W-1:0]  r_wr;
    logic [DIVR_W-1:0] r_sum_c;
    logic [DIVR_W-1:0] r_sum_r;
    logic [AREA_W-1:0] r_cell_w;
    logic [AREA_W-1:0] r_cell_h;

    // cursor
    logic [COL_W-1:0]     r_cur_col;
    logic [ROW_W-1:0]     r_cur_row;
    logic [SIZE_BITS-1:0] r_cursor_x;
    logic [SIZE_BITS-1:0] r_cursor_y;

    // result register
    logic                     r_out_valid;
    logic signed [POS_W-1:0]  r_pos_x;
    logic signed [POS_W-1:0]  r_pos_y;
    logic signed [SIZE_W-1:0] r_size_w;
    logic signed [SIZE_W-1:0] r_size_h;

    logic              w_req_acc;
    logic              w_cfg_acc;
    logic              w_in_ready;
    logic              w_div_start;
    logic              w_fin_go;
    logic [CNT_W-1:0]  w_cols;
    logic [CNT_W-1:0]  w_rows;
    logic [COL_W-1:0]  w_col;
    logic [ROW_W-1:0]  w_row;
    logic [AREA_W-1:0] w_mul_a;
    logic [WGT_W-1:0]  w_mul_b;
    logic [PROD_W-1:0] w_prod;
    logic [DIVR_W-1:0] w_divisor;
    t_div_stat         w_div_stat;
    logic [AREA_W-1:0] w_quot;
    t_edge             w_edge_x;
    t_edge             w_edge_y;
    logic signed [POS_W-1:0]  w_pos_x;
    logic signed [POS_W-1:0]  w_pos_y;
    logic signed [SIZE_W-1:0] w_size_w;
    logic signed [SIZE_W-1:0] w_size_h;
    logic [CNT_W-1:0]     w_col_inc;
    logic [CNT_W-1:0]     w_row_inc;
    logic                 w_col_wrap;
    logic [CUR_W-1:0]     w_cx_sum;
    logic [CUR_W-1:0]     w_cy_sum;

    assign w_req_acc = i_req.valid && w_in_ready;
    assign w_cfg_acc = i_cfg.valid;
    assign i_req.ready = w_in_ready;
    assign i_cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ncol <= CNT_W'(1);
            r_cfg_nrow <= CNT_W'(1);
            r_cfg_wcol <= WEIGHT_RESET;
            r_cfg_wrow <= WEIGHT_RESET;
        end else if (w_cfg_acc) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_COL_COUNT:   r_cfg_ncol <= i_cfg.data[CNT_W-1:0];
                CFG_ROW_COUNT:   r_cfg_nrow <= i_cfg.data[CNT_W-1:0];
                CFG_COL_WEIGHTS: r_cfg_wcol <= i_cfg.data;
                CFG_ROW_WEIGHTS: r_cfg_wrow <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_req_acc && !i_req.req_type) n_state = ST_PREP;
            ST_PREP:  n_state = ST_MUL_X;
            ST_MUL_X: n_state = ST_DIV_X;
            ST_DIV_X: if (w_div_stat.done) n_state = ST_MUL_Y;
            ST_MUL_Y: n_state = ST_DIV_Y;
            ST_DIV_Y: if (w_div_stat.done) n_state = ST_FIN;
            ST_FIN:   if (w_fin_go) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_in_ready  = (r_state == ST_IDLE);
        w_div_start = (r_state == ST_MUL_X) || (r_state == ST_MUL_Y);
        w_fin_go    = (r_state == ST_FIN) && (!r_out_valid || o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // cell selection, a stale cursor column or row falls back to zero
    assign w_cols = clamp_count(r_cfg_ncol, CNT_W'(MAX_COLS));
    assign w_rows = clamp_count(r_cfg_nrow, CNT_W'(MAX_ROWS));
    assign w_col  = (CNT_W'(r_cur_col) < w_cols) ? r_cur_col : '0;
    assign w_row  = (CNT_W'(r_cur_row) < w_rows) ? r_cur_row : '0;

    always_ff @(posedge i_clk) begin
        if (w_req_acc) begin
            r_ax  <= i_req.area_x;
            r_ay  <= i_req.area_y;
            r_aw  <= i_req.area_w;
            r_ah  <= i_req.area_h;
            r_pad <= i_req.pad;
            r_bm  <= (EDGE_W+1)'(i_req.item_border) + (EDGE_W+1)'(i_req.item_margin);
            r_pw  <= i_req.pref_w;
            r_ph  <= i_req.pref_h;
        end
        if (r_state == ST_PREP) begin
            r_cols  <= w_cols;
            r_rows  <= w_rows;
            r_col   <= w_col;
            r_row   <= w_row;
            r_wc    <= r_cfg_wcol[WGT_W*w_col +: WGT_W];
            r_wr    <= r_cfg_wrow[WGT_W*w_row +: WGT_W];
            r_sum_c <= weight_sum(r_cfg_wcol, w_cols);
            r_sum_r <= weight_sum(r_cfg_wrow, w_rows);
        end
        // a zero weight sum gives empty cells
        if (r_state == ST_DIV_X && w_div_stat.done) begin
            r_cell_w <= (r_sum_c == '0) ? '0 : w_quot;
        end
        if (r_state == ST_DIV_Y && w_div_stat.done) begin
            r_cell_h <= (r_sum_r == '0) ? '0 : w_quot;
        end
    end

    // shared multiplier, product goes straight into the divider registers
    assign w_mul_a   = (r_state == ST_MUL_Y) ? r_ah : r_aw;
    assign w_mul_b   = (r_state == ST_MUL_Y) ? r_wr : r_wc;
    assign w_prod    = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    assign w_divisor = (r_state == ST_MUL_Y) ? r_sum_r : r_sum_c;

    gcp_divider #(
        .DIVR_W (DIVR_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (w_divisor),
        .o_stat     (w_div_stat),
        .o_quot     (w_quot)
    );

    assign w_edge_x.first = (r_col == '0);
    assign w_edge_x.last  = (CNT_W'(r_col) == r_cols - 1'b1);
    assign w_edge_y.first = (r_row == '0);
    assign w_edge_y.last  = (CNT_W'(r_row) == r_rows - 1'b1);

    gcp_axis #(
        .SIZE_BITS (SIZE_BITS)
    ) u_axis_x (
        .i_org    (r_ax),
        .i_cursor (r_cursor_x),
        .i_cell   (r_cell_w),
        .i_pad    (r_pad),
        .i_bm     (r_bm),
        .i_pref   (r_pw),
        .i_edge   (w_edge_x),
        .o_pos    (w_pos_x),
        .o_size   (w_size_w)
    );

    gcp_axis #(
        .SIZE_BITS (SIZE_BITS)
    ) u_axis_y (
        .i_org    (r_ay),
        .i_cursor (r_cursor_y),
        .i_cell   (r_cell_h),
        .i_pad    (r_pad),
        .i_bm     (r_bm),
        .i_pref   (r_ph),
        .i_edge   (w_edge_y),
        .o_pos    (w_pos_y),
        .o_size   (w_size_h)
    );

    // cursor advance, row steps when the column wraps
    assign w_col_inc  = CNT_W'(r_col) + 1'b1;
    assign w_row_inc  = CNT_W'(r_row) + 1'b1;
    assign w_col_wrap = (w_col_inc == r_cols);
    assign w_cx_sum   = CUR_W'(r_cursor_x) + CUR_W'(r_cell_w);
    assign w_cy_sum   = CUR_W'(r_cursor_y) + CUR_W'(r_cell_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col  <= '0;
            r_cur_row  <= '0;
            r_cursor_x <= '0;
            r_cursor_y <= '0;
        end else if (w_req_acc && i_req.req_type) begin
            r_cur_col  <= '0;
            r_cur_row  <= '0;
            r_cursor_x <= '0;
            r_cursor_y <= '0;
        end else if (w_fin_go) begin
            r_cur_col  <= w_col_wrap ? '0 : w_col_inc[COL_W-1:0];
            r_cursor_x <= (w_cx_sum >= CUR_W'(r_aw)) ? '0 : w_cx_sum[SIZE_BITS-1:0];
            if (w_col_wrap) begin
                r_cursor_y <= (w_cy_sum >= CUR_W'(r_ah)) ? '0 : w_cy_sum[SIZE_BITS-1:0];
                r_cur_row  <= (w_row_inc == r_rows) ? '0 : w_row_inc[ROW_W-1:0];
            end else begin
                r_cur_row  <= r_row;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_go) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            r_pos_x  <= w_pos_x;
            r_pos_y  <= w_pos_y;
            r_size_w <= w_size_w;
            r_size_h <= w_size_h;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.pos_x  = r_pos_x;
    assign o_res.pos_y  = r_pos_y;
    assign o_res.size_w = r_size_w;
    assign o_res.size_h = r_size_h;

endmodule
